@@ sv/klex_pkg.sv @@
// klex_pkg: shared types, constants and keyword tables for the keyword token lexer.
// Used by klex_front, klex_queue, klex_back and keyword_token_lexer.
// No dependencies.
package klex_pkg;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned LEN_W  = 8;
  localparam int unsigned NUM_KW = 4;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_IDENT,
    MODE_MINUS,
    MODE_ERROR
  } scan_mode_e;

  typedef enum logic [3:0] {
    TOK_NUMBER = 4'd0,
    TOK_IDENT  = 4'd1,
    TOK_CONST  = 4'd2,
    TOK_FN     = 4'd3,
    TOK_RETURN = 4'd4,
    TOK_I32    = 4'd5,
    TOK_EQUALS = 4'd6,
    TOK_LPAREN = 4'd7,
    TOK_RPAREN = 4'd8,
    TOK_LBRACE = 4'd9,
    TOK_RBRACE = 4'd10,
    TOK_ARROW  = 4'd11,
    TOK_EOF    = 4'd12,
    TOK_ERROR  = 4'd13
  } token_kind_e;

  typedef struct packed {
    token_kind_e      kind;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] column;
    logic [LEN_W-1:0] length;
  } token_t;

  // one or two tokens raised by a single input byte
  typedef struct packed {
    token_t first;
    token_t second;
    logic   two;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{8'd5, 8'd2, 8'd6, 8'd3};

  function automatic logic [7:0] kw_byte(input logic [1:0] k, input logic [2:0] p);
    logic [7:0] b;
    b = CH_NUL;
    unique case (k)
      2'd0: begin
        unique case (p)
          3'd0: b = "c";
          3'd1: b = "o";
          3'd2: b = "n";
          3'd3: b = "s";
          3'd4: b = "t";
          default: b = CH_NUL;
        endcase
      end
      2'd1: begin
        unique case (p)
          3'd0: b = "f";
          3'd1: b = "n";
          default: b = CH_NUL;
        endcase
      end
      2'd2: begin
        unique case (p)
          3'd0: b = "r";
          3'd1: b = "e";
          3'd2: b = "t";
          3'd3: b = "u";
          3'd4: b = "r";
          3'd5: b = "n";
          default: b = CH_NUL;
        endcase
      end
      default: begin
        unique case (p)
          3'd0: b = "i";
          3'd1: b = "3";
          3'd2: b = "2";
          default: b = CH_NUL;
        endcase
      end
    endcase
    return b;
  endfunction

  function automatic token_kind_e kw_kind(input logic [1:0] k);
    token_kind_e t;
    unique case (k)
      2'd0:    t = TOK_CONST;
      2'd1:    t = TOK_FN;
      2'd2:    t = TOK_RETURN;
      default: t = TOK_I32;
    endcase
    return t;
  endfunction

  // keywords still consistent after byte c at position p
  function automatic logic [NUM_KW-1:0] kw_hit(input logic [LEN_W-1:0] p,
                                               input logic [7:0] c);
    logic [NUM_KW-1:0] h;
    for (int k = 0; k < NUM_KW; k++) begin
      h[k] = (p < KW_LEN[k]) && (kw_byte(2'(k), p[2:0]) == c);
    end
    return h;
  endfunction

endpackage

@@ sv/klex_front.sv @@
// klex_front: byte classifier and scanner state; builds the token bundle for each byte.
// Depends on klex_pkg.
module klex_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [7:0]                  text_byte_i,
  input  logic                        end_of_text_i,
  output logic                        push_o,
  output klex_pkg::bundle_t           bundle_o
);
  import klex_pkg::*;

  scan_mode_e        mode_q, mode_d;
  logic [POS_W-1:0]  line_q, line_d;
  logic [POS_W-1:0]  col_q, col_d;
  logic [LEN_W-1:0]  run_q, run_d;
  logic [NUM_KW-1:0] mask_q, mask_d;
  logic [POS_W-1:0]  mcol_q, mcol_d;

  logic              is_end, is_digit, is_alpha, is_word, is_space;
  logic [POS_W-1:0]  line_mv, col_mv;
  logic [LEN_W-1:0]  run_inc;
  token_kind_e       word_kind, single_kind;
  token_t            word_tok, tok_a, tok_b;
  logic              have_a, have_b, idle_path;

  assign is_end   = end_of_text_i || (text_byte_i == CH_NUL);
  assign is_digit = (text_byte_i >= "0") && (text_byte_i <= "9");
  assign is_alpha = ((text_byte_i >= "a") && (text_byte_i <= "z")) ||
                    ((text_byte_i >= "A") && (text_byte_i <= "Z"));
  assign is_word  = is_digit || is_alpha || (text_byte_i == CH_UNDER);
  assign is_space = (text_byte_i == CH_SPACE) || (text_byte_i == CH_TAB) ||
                    (text_byte_i == CH_CR) || (text_byte_i == CH_LF);

  assign run_inc = (run_q == LEN_MAX) ? run_q : LEN_W'(run_q + 1'b1);

  always_comb begin
    if (text_byte_i == CH_LF) begin
      line_mv = (line_q == POS_MAX) ? line_q : POS_W'(line_q + 1'b1);
      col_mv  = POS_ONE;
    end else begin
      line_mv = line_q;
      col_mv  = (col_q == POS_MAX) ? col_q : POS_W'(col_q + 1'b1);
    end
  end

  always_comb begin
    word_kind = (mode_q == MODE_IDENT) ? TOK_IDENT : TOK_NUMBER;
    if (mode_q == MODE_IDENT) begin
      for (int k = 0; k < NUM_KW; k++) begin
        if (mask_q[k] && (run_q == KW_LEN[k])) word_kind = kw_kind(2'(k));
      end
    end
  end

  assign word_tok = '{kind: word_kind, line: line_q, column: col_q, length: run_q};

  always_comb begin
    unique case (text_byte_i)
      CH_EQUALS: single_kind = TOK_EQUALS;
      CH_LPAREN: single_kind = TOK_LPAREN;
      CH_RPAREN: single_kind = TOK_RPAREN;
      CH_LBRACE: single_kind = TOK_LBRACE;
      CH_RBRACE: single_kind = TOK_RBRACE;
      default:   single_kind = TOK_ERROR;
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    line_d    = line_q;
    col_d     = col_q;
    run_d     = run_q;
    mask_d    = mask_q;
    mcol_d    = mcol_q;
    tok_a     = word_tok;
    tok_b     = word_tok;
    have_a    = 1'b0;
    have_b    = 1'b0;
    idle_path = 1'b0;

    if (is_end) begin
      if ((mode_q == MODE_NUMBER) || (mode_q == MODE_IDENT)) begin
        have_a = 1'b1;
      end else if (mode_q == MODE_MINUS) begin
        have_a = 1'b1;
        tok_a  = '{kind: TOK_ERROR, line: line_q, column: mcol_q, length: LEN_W'(1)};
      end
      if (have_a) begin
        have_b = 1'b1;
        tok_b  = '{kind: TOK_EOF, line: line_q, column: col_q, length: '0};
      end else begin
        have_a = 1'b1;
        tok_a  = '{kind: TOK_EOF, line: line_q, column: col_q, length: '0};
      end
      mode_d = MODE_IDLE;
      line_d = POS_ONE;
      col_d  = POS_ONE;
      run_d  = '0;
      mask_d = '1;
      mcol_d = '0;
    end else begin
      unique case (mode_q)
        MODE_NUMBER, MODE_IDENT: begin
          if (is_digit || ((mode_q == MODE_IDENT) && is_word)) begin
            run_d  = run_inc;
            mask_d = mask_q & kw_hit(run_q, text_byte_i);
            line_d = line_mv;
            col_d  = col_mv;
          end else begin
            have_a    = 1'b1;
            mode_d    = MODE_IDLE;
            idle_path = 1'b1;
          end
        end
        MODE_MINUS: begin
          have_a = 1'b1;
          if (text_byte_i == CH_GT) begin
            tok_a  = '{kind: TOK_ARROW, line: line_q, column: mcol_q, length: LEN_W'(2)};
            line_d = line_mv;
            col_d  = col_mv;
            mode_d = MODE_IDLE;
          end else begin
            tok_a  = '{kind: TOK_ERROR, line: line_q, column: mcol_q, length: LEN_W'(1)};
            mode_d = MODE_ERROR;
          end
        end
        MODE_IDLE:  idle_path = 1'b1;
        MODE_ERROR: ;
        default:    mode_d = MODE_IDLE;
      endcase

      if (idle_path) begin
        if (is_space) begin
          line_d = line_mv;
          col_d  = col_mv;
        end else if (is_word) begin
          mode_d = is_digit ? MODE_NUMBER : MODE_IDENT;
          run_d  = LEN_W'(1);
          mask_d = kw_hit('0, text_byte_i);
          line_d = line_mv;
          col_d  = col_mv;
        end else if (text_byte_i == CH_MINUS) begin
          mode_d = MODE_MINUS;
          mcol_d = col_q;
          line_d = line_mv;
          col_d  = col_mv;
        end else begin
          if (have_a) begin
            have_b = 1'b1;
            tok_b  = '{kind: single_kind, line: line_q, column: col_q, length: LEN_W'(1)};
          end else begin
            have_a = 1'b1;
            tok_a  = '{kind: single_kind, line: line_q, column: col_q, length: LEN_W'(1)};
          end
          if (single_kind == TOK_ERROR) begin
            mode_d = MODE_ERROR;
          end else begin
            line_d = line_mv;
            col_d  = col_mv;
          end
        end
      end
    end
  end

  assign push_o   = accept_i && have_a;
  assign bundle_o = '{first: tok_a, second: tok_b, two: have_b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      line_q <= POS_ONE;
      col_q  <= POS_ONE;
      run_q  <= '0;
      mask_q <= '1;
      mcol_q <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      line_q <= line_d;
      col_q  <= col_d;
      run_q  <= run_d;
      mask_q <= mask_d;
      mcol_q <= mcol_d;
    end
  end

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (mode_q == MODE_ERROR) && !is_end |=> mode_q == MODE_ERROR)
    else $error("scanner left error mode before end of text");

endmodule

@@ sv/klex_queue.sv @@
// klex_queue: small bundle queue between scanner front and token back end.
// Depends on klex_pkg.
module klex_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  klex_pkg::bundle_t       wdata_i,
  input  logic                    pop_i,
  output klex_pkg::bundle_t       rdata_o,
  output klex_pkg::queue_status_t status_o
);
  import klex_pkg::*;

  bundle_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wptr_q, rptr_q;
  logic [QCNT_W-1:0]  cnt_q;

  assign status_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign rdata_o        = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= QPTR_W'(wptr_q + 1'b1);
      if (pop_i)  rptr_q <= QPTR_W'(rptr_q + 1'b1);
      if (push_i && !pop_i) begin
        cnt_q <= QCNT_W'(cnt_q + 1'b1);
      end else if (pop_i && !push_i) begin
        cnt_q <= QCNT_W'(cnt_q - 1'b1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.full |-> !push_i)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.empty |-> !pop_i)
    else $error("pop from empty queue");

endmodule

@@ sv/klex_back.sv @@
// klex_back: unpacks bundles into single tokens and drives the output register.
// Depends on klex_pkg.
module klex_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  klex_pkg::bundle_t       bundle_i,
  input  klex_pkg::queue_status_t status_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output klex_pkg::token_t        token_o,
  output logic                    last_o
);
  import klex_pkg::*;

  logic   out_valid_q, last_q, sec_valid_q;
  token_t tok_q, sec_q;
  logic   load;

  assign load  = !out_valid_q || out_ready_i;
  assign pop_o = load && !sec_valid_q && !status_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sec_valid_q <= 1'b0;
    end else if (load) begin
      if (sec_valid_q) begin
        out_valid_q <= 1'b1;
        sec_valid_q <= 1'b0;
      end else if (!status_i.empty) begin
        out_valid_q <= 1'b1;
        sec_valid_q <= bundle_i.two;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (sec_valid_q) begin
        tok_q  <= sec_q;
        last_q <= 1'b1;
      end else begin
        tok_q  <= bundle_i.first;
        last_q <= !bundle_i.two;
        sec_q  <= bundle_i.second;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign token_o     = tok_q;
  assign last_o      = last_q;

  a_second_behind_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_valid_q |-> out_valid_q && !last_q)
    else $error("held second token without a first one on the output");

  a_second_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_valid_q && out_ready_i |=> out_valid_q && last_q)
    else $error("second token not shown as last of its byte");

endmodule

@@ sv/keyword_token_lexer.sv @@
// keyword_token_lexer: streaming tokenizer, one source byte in, tokens out.
// The first token of a byte goes through the bundle queue to the output register; a
// second from the same byte follows it. One byte per cycle is taken while the 4-entry
// bundle queue has room; one token per cycle leaves while tokens wait and out_ready_i
// is high. Reset clears the queue and output valid; scanner idles at line 1, column 1.
// Depends on klex_pkg, klex_front, klex_queue, klex_back.
module keyword_token_lexer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   text_byte_i,
  input  logic                         end_of_text_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [3:0]                   token_kind_o,
  output logic [klex_pkg::POS_W-1:0]   token_line_o,
  output logic [klex_pkg::POS_W-1:0]   token_column_o,
  output logic [klex_pkg::LEN_W-1:0]   token_length_o,
  output logic                         last_of_run_o
);
  import klex_pkg::*;

  logic          accept, push, pop;
  bundle_t       wbundle, rbundle;
  queue_status_t qstat;
  token_t        tok;

  assign in_ready_o = !qstat.full;
  assign accept     = in_valid_i && in_ready_o;

  klex_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i      (accept),
    .text_byte_i,
    .end_of_text_i,
    .push_o        (push),
    .bundle_o      (wbundle)
  );

  klex_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i   (push),
    .wdata_i  (wbundle),
    .pop_i    (pop),
    .rdata_o  (rbundle),
    .status_o (qstat)
  );

  klex_back u_back (
    .clk_i,
    .rst_ni,
    .bundle_i    (rbundle),
    .status_i    (qstat),
    .pop_o       (pop),
    .out_valid_o,
    .out_ready_i,
    .token_o     (tok),
    .last_o      (last_of_run_o)
  );

  assign token_kind_o   = 4'(tok.kind);
  assign token_line_o   = tok.line;
  assign token_column_o = tok.column;
  assign token_length_o = tok.length;

endmodule

@@ bench/keyword_token_lexer_tb.sv @@
// keyword_token_lexer_tb: self-checking bench for the keyword token lexer. It feeds
// directed, random and length-saturating source text and predicts every token.
// Depends on klex_pkg and keyword_token_lexer.
module keyword_token_lexer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import klex_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef struct {
    token_kind_e      kind;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] column;
    logic [LEN_W-1:0] length;
    logic             last;
  } expected_tok_t;

  class lex_tracker;
    expected_tok_t    expected_q[$];
    int unsigned      faults;
    scan_mode_e       mode;
    logic [POS_W-1:0] line_no;
    logic [POS_W-1:0] col_no;
    logic [POS_W-1:0] minus_col;
    logic [LEN_W-1:0] run_len;
    logic [3:0]       live_kw;
    string            kw_word [4];
    token_kind_e      kw_tok [4];

    function new();
      kw_word = '{"const", "fn", "return", "i32"};
      kw_tok  = '{TOK_CONST, TOK_FN, TOK_RETURN, TOK_I32};
      faults  = 0;
      rearm();
    endfunction

    function void rearm();
      mode      = MODE_IDLE;
      line_no   = POS_ONE;
      col_no    = POS_ONE;
      minus_col = '0;
      run_len   = '0;
      live_kw   = 4'hF;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function void push_tok(token_kind_e k, logic [POS_W-1:0] ln, logic [POS_W-1:0] col,
                           logic [LEN_W-1:0] len);
      expected_tok_t t;
      t.kind   = k;
      t.line   = ln;
      t.column = col;
      t.length = len;
      t.last   = 1'b0;
      expected_q = {expected_q, t};
    endfunction

    function void advance(logic [7:0] c);
      if (c == CH_LF) begin
        if (line_no != POS_MAX) line_no++;
        col_no = POS_ONE;
      end else if (col_no != POS_MAX) begin
        col_no++;
      end
    endfunction

    // narrows the keyword candidates by position, then counts the character
    function void absorb(logic [7:0] c);
      for (int i = 0; i < 4; i++) begin
        if (run_len >= kw_word[i].len() || kw_word[i][run_len] != c) live_kw[i] = 1'b0;
      end
      if (run_len != LEN_MAX) run_len++;
      advance(c);
    endfunction

    function void close_word();
      token_kind_e k;
      k = TOK_NUMBER;
      if (mode == MODE_IDENT) begin
        k = TOK_IDENT;
        for (int i = 0; i < 4; i++) begin
          if (live_kw[i] && run_len == kw_word[i].len()) k = kw_tok[i];
        end
      end
      push_tok(k, line_no, col_no, run_len);
      mode = MODE_IDLE;
    endfunction

    function void between_tokens(logic [7:0] c);
      token_kind_e k;
      if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
        advance(c);
        return;
      end
      if (is_digit(c) || is_alpha(c) || c == CH_UNDER) begin
        mode    = is_digit(c) ? MODE_NUMBER : MODE_IDENT;
        run_len = '0;
        live_kw = 4'hF;
        absorb(c);
        return;
      end
      if (c == CH_MINUS) begin
        mode      = MODE_MINUS;
        minus_col = col_no;
        advance(c);
        return;
      end
      case (c)
        CH_EQUALS: k = TOK_EQUALS;
        CH_LPAREN: k = TOK_LPAREN;
        CH_RPAREN: k = TOK_RPAREN;
        CH_LBRACE: k = TOK_LBRACE;
        CH_RBRACE: k = TOK_RBRACE;
        default:   k = TOK_ERROR;
      endcase
      push_tok(k, line_no, col_no, 8'd1);
      if (k == TOK_ERROR) mode = MODE_ERROR;
      else advance(c);
    endfunction

    // predicts the tokens raised by one accepted request
    function void note_byte(logic [7:0] c, logic eot);
      int unsigned held;
      held = expected_q.size();
      if (eot || c == CH_NUL) begin
        if (mode == MODE_NUMBER || mode == MODE_IDENT) close_word();
        else if (mode == MODE_MINUS) push_tok(TOK_ERROR, line_no, minus_col, 8'd1);
        push_tok(TOK_EOF, line_no, col_no, '0);
        rearm();
      end else begin
        case (mode)
          MODE_NUMBER: begin
            if (is_digit(c)) absorb(c);
            else begin
              close_word();
              between_tokens(c);
            end
          end
          MODE_IDENT: begin
            if (is_digit(c) || is_alpha(c) || c == CH_UNDER) absorb(c);
            else begin
              close_word();
              between_tokens(c);
            end
          end
          MODE_MINUS: begin
            if (c == CH_GT) begin
              push_tok(TOK_ARROW, line_no, minus_col, 8'd2);
              advance(c);
              mode = MODE_IDLE;
            end else begin
              push_tok(TOK_ERROR, line_no, minus_col, 8'd1);
              mode = MODE_ERROR;
            end
          end
          MODE_IDLE: between_tokens(c);
          default: ;
        endcase
      end
      if (expected_q.size() > held) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function void flag(string field, int unsigned want, int unsigned got);
      if (faults < 40) $error("%s: expected %0d, got %0d", field, want, got);
      faults++;
    endfunction

    function void check_token(logic [3:0] kind, logic [POS_W-1:0] ln,
                              logic [POS_W-1:0] col, logic [LEN_W-1:0] len, logic last);
      expected_tok_t t;
      if (expected_q.size() == 0) begin
        if (faults < 40) $error("token with none pending: kind %0d", kind);
        faults++;
        return;
      end
      t = expected_q.pop_front();
      if (kind !== t.kind) flag("token_kind", t.kind, kind);
      if (ln !== t.line) flag("token_line", t.line, ln);
      if (col !== t.column) flag("token_column", t.column, col);
      if (len !== t.length) flag("token_length", t.length, len);
      if (last !== t.last) flag("last_of_run", t.last, last);
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [7:0]        text_byte_i = '0;
  logic              end_of_text_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [3:0]        token_kind_o;
  logic [POS_W-1:0]  token_line_o;
  logic [POS_W-1:0]  token_column_o;
  logic [LEN_W-1:0]  token_length_o;
  logic              last_of_run_o;

  lex_tracker  tracker = new();
  bit          calm = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned stall_cycles = 0;

  string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string keyword_forms [12] = '{"const", "fn", "return", "i32", "con", "constx", "fnn",
                                "f", "returned", "i3", "i320", "I32"};
  string puncts [6] = '{"=", "(", ")", "{", "}", "->"};
  string gaps [6] = '{" ", "\t", "\r", "\n", "\r\n", " \t\n"};

  keyword_token_lexer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .text_byte_i    (text_byte_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .token_line_o   (token_line_o),
    .token_column_o (token_column_o),
    .token_length_o (token_length_o),
    .last_of_run_o  (last_of_run_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) tracker.note_byte(text_byte_i, end_of_text_i);
      if (out_valid_o && out_ready_i) begin
        tracker.check_token(token_kind_o, token_line_o, token_column_o, token_length_o,
                            last_of_run_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 16);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eot);
    while (!calm && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic send_end();
    if ($urandom_range(1)) send_byte(8'($urandom_range(255)), 1'b1);
    else send_byte(CH_NUL, 1'b0);
  endtask

  function automatic string random_run(int unsigned n, bit numeric);
    string s;
    int unsigned idx;
    s = "";
    for (int i = 0; i < n; i++) begin
      if (numeric) idx = 53 + $urandom_range(9);
      else if (i == 0) idx = $urandom_range(52);
      else idx = $urandom_range(62);
      s = {s, word_chars.substr(idx, idx)};
    end
    return s;
  endfunction

  function automatic string word_piece();
    int unsigned roll;
    int unsigned n;
    roll = $urandom_range(99);
    n = ($urandom_range(149) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 8);
    if (roll < 25) return keyword_forms[$urandom_range(11)];
    if (roll < 45) return random_run(n, 1'b0);
    if (roll < 60) return random_run(n, 1'b1);
    return puncts[$urandom_range(5)];
  endfunction

  // one source text: mostly well-formed pieces, some noise and stray minus signs
  task automatic send_program();
    int unsigned roll;
    repeat ($urandom_range(4, 24)) begin
      roll = $urandom_range(99);
      if (roll < 4) send_byte(8'($urandom_range(255)), 1'b0);
      else if (roll < 7) send_text("-");
      else send_text(word_piece());
      if ($urandom_range(2) == 0) send_text(gaps[$urandom_range(5)]);
    end
    send_end();
  endtask

  initial begin
    int unsigned random_base;
    bit pressed;
    pressed = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every punctuation kind, arrow, number cut short by a letter, end on a zero byte
    send_text("fn(){}=->9a");
    send_byte(CH_NUL, 1'b0);
    // lone minus, then sticky error swallowing a high byte, end flag with payload
    send_text("-q");
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // minus right before the end
    send_text("-");
    send_byte(8'h00, 1'b1);
    // non-ASCII byte
    send_byte(8'hC3, 1'b0);
    send_byte(8'h7F, 1'b1);

    random_base = bytes_sent;
    while (bytes_sent - random_base < RANDOM_ITEMS) begin
      calm = (bytes_sent - random_base >= 300) && (bytes_sent - random_base < 600);
      if (!pressed && bytes_sent - random_base > 800) begin
        pressed = 1'b1;
        hold_request = 1'b1;
        repeat (40) send_byte(CH_LPAREN, 1'b0);
      end
      send_program();
    end
    calm = 1'b0;

    // saturate token length
    send_text("ab=");
    send_text(random_run(300, 1'b0));
    send_text(" ");
    send_text("x");
    send_end();

    in_valid_i <= 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.faults == 0 && tracker.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
